>>> rtl/kld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kld_pkg: shared types and constants for the histogram KL divergence block
// Holds the fixed field widths, the accumulator limits, the ln(2) constant
// and the result type of the mantissa normalizer.
// ----------------------------------------------------------------------------
package kld_pkg;

    localparam int P_W    = 25;  // bin value width, unsigned Q1.24 below 2.0
    localparam int T_W    = 24;  // threshold width and fraction bits of the sum
    localparam int SUM_W  = 48;  // signed Q24.24 accumulator
    localparam int MANT_W = 31;  // normalized mantissa, Q1.30
    localparam int EXP_W  = 5;   // leading-one position of a bin value
    localparam int MAG_W  = 30;  // magnitude of one bin's term
    localparam int MUL_W  = 32;  // operand width of the shared multiplier

    // floor(ln(2) * 2^32)
    localparam logic [31:0] LN2_Q32 = 32'd2977044471;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [T_W-1:0] THR_RESET = 24'd16;

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  expo;
    } t_norm;

endpackage

>>> rtl/kld_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kld_norm: leading-one normalizer
// Finds the leading one of a nonzero bin value and left-aligns the value so
// that it becomes a Q1.30 mantissa in [1.0, 2.0).
// ----------------------------------------------------------------------------
module kld_norm
    import kld_pkg::*;
(
    input  logic [P_W-1:0] i_x,
    output t_norm          o_norm
);

    logic [EXP_W-1:0] expo;

    always_comb begin
        expo = '0;
        for (int i = 0; i < P_W; i++) begin
            if (i_x[i]) begin
                expo = EXP_W'(i);
            end
        end
    end

    assign o_norm.expo = expo;
    assign o_norm.mant = {{(MANT_W-P_W){1'b0}}, i_x} << (EXP_W'(MANT_W-1) - expo);

endmodule

>>> rtl/kld_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kld_mul: shared unsigned multiplier
// One 32 x 32 bit product per cycle, used in turn for the mantissa squaring
// of the logarithm, the ln(2) scaling and the final weighting by p.
// ----------------------------------------------------------------------------
module kld_mul
    import kld_pkg::*;
(
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic [2*MUL_W-1:0] o_p
);

    assign o_p = 64'(i_a) * 64'(i_b);

endmodule

>>> rtl/histogram_kl_divergence_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_kl_divergence_top: discrete Kullback-Leibler divergence
// Accumulates p*ln(p/q) over histogram bin pairs and reports the sum on the
// bin marked last.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries one bin pair, p and q, as unsigned Q1.24 values,
// plus a flag that marks the final bin. The input beat is taken when i_valid
// is high and o_stall is low. A bin whose p and q both sit at or below the
// skip threshold, or whose p is zero, adds nothing. A counted bin with q
// zero sets the sticky infinity flag without any multiply.
// Any other counted bin runs through the shared multiplier: FRAC_BITS
// squaring steps for log2(p), FRAC_BITS for log2(q), a step to form the
// difference, three multiplies and one accumulate, and o_stall stays high
// until the accumulate is done; the squaring loop of the logarithm is most
// of that work. On the last bin the emit state moves the sum into the
// output register, which shows it with o_valid until the receiver takes
// it with i_stall low. While the receiver stalls, the next histogram still
// runs; only a further last bin waits until the output register is free.
// Reset sets the skip threshold to 16 (Q0.24), clears the sum and the
// infinity flag and empties the output register. The user must write the
// threshold with i_cfg_we only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module histogram_kl_divergence_top
    import kld_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [T_W-1:0]          i_cfg_data,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [P_W-1:0]          i_prob_a,
    input  logic [P_W-1:0]          i_prob_b,
    input  logic                    i_last_bin,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_divergence,
    output logic                    o_infinite
);

    // Log values carry a signed integer part in [-24, 0] above FRAC_BITS
    // fraction bits; their difference stays below 25 in magnitude.
    localparam int LOG_W = FRAC_BITS + 6;
    localparam int M_W   = FRAC_BITS + 5;
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int SH_R  = (FRAC_BITS >= T_W) ? FRAC_BITS - T_W : 0;
    localparam int SH_L  = (FRAC_BITS < T_W) ? T_W - FRAC_BITS : 0;
    localparam logic [MUL_W-1:0] C_LN2 = MUL_W'(LN2_Q32 >> (32 - FRAC_BITS));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOGP,
        S_LOGQ,
        S_DIFF,
        S_MUL_I,
        S_MUL_F,
        S_MUL_P,
        S_ACC,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [T_W-1:0]        r_thr;
    logic [P_W-1:0]        r_p;
    logic [P_W-1:0]        r_q;
    logic                  r_last;
    logic [MANT_W-1:0]     r_y;
    logic [EXP_W-1:0]      r_e;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [CNT_W-1:0]      r_cnt;
    logic [LOG_W-1:0]      r_lp;
    logic                  r_neg;
    logic [M_W-1:0]        r_m;
    logic [M_W-1:0]        r_l;
    logic [MAG_W-1:0]      r_mag;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_inf;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_div;
    logic                  r_out_inf;

    logic                  counted;
    logic [P_W-1:0]        norm_x;
    t_norm                 norm;
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic [MUL_W-1:0]      sq_t;
    logic                  sq_bit;
    logic [MANT_W-1:0]     n_y;
    logic [FRAC_BITS-1:0]  n_frac;
    logic [LOG_W-1:0]      n_lp;
    logic [LOG_W-1:0]      lq;
    logic [LOG_W:0]        diff;
    logic [LOG_W:0]        diff_abs;
    logic [63:0]           l_ext;
    logic [SUM_W:0]        acc_sum;
    logic [SUM_W:0]        term;
    logic [SUM_W-1:0]      n_sum;

    // A bin counts when either value is above the threshold; zero p adds nothing.
    assign counted = ((i_prob_a > {1'b0, r_thr}) || (i_prob_b > {1'b0, r_thr}))
                     && (i_prob_a != '0);

    // The normalizer sees p at accept time and q when the first log is done.
    assign norm_x = (r_state == S_IDLE) ? i_prob_a : r_q;

    kld_norm u_norm (
        .i_x    (norm_x),
        .o_norm (norm)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_LOGP, S_LOGQ: begin
                mul_a = MUL_W'(r_y);
                mul_b = MUL_W'(r_y);
            end
            S_MUL_I: begin
                mul_a = MUL_W'(r_m[FRAC_BITS +: 5]);
                mul_b = C_LN2;
            end
            S_MUL_F: begin
                mul_a = MUL_W'(r_m[FRAC_BITS-1:0]);
                mul_b = C_LN2;
            end
            S_MUL_P: begin
                mul_a = MUL_W'(r_p);
                mul_b = l_ext[MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    kld_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    // One bit of the logarithm per squaring: a square at or above 2.0
    // yields a one and is halved back into [1.0, 2.0).
    assign sq_t   = mul_p[2*MANT_W-1 -: MUL_W];
    assign sq_bit = sq_t[MUL_W-1];
    assign n_y    = sq_bit ? sq_t[MUL_W-1:1] : sq_t[MANT_W-1:0];
    assign n_frac = {r_frac[FRAC_BITS-2:0], sq_bit};

    assign n_lp = {6'({1'b0, r_e}) - 6'(T_W), n_frac};
    assign lq   = {6'({1'b0, r_e}) - 6'(T_W), r_frac};

    assign diff     = {r_lp[LOG_W-1], r_lp} - {lq[LOG_W-1], lq};
    assign diff_abs = diff[LOG_W] ? (~diff + 1'b1) : diff;

    // Scaled natural log brought to 24 fraction bits.
    assign l_ext = (64'(r_l) >> SH_R) << SH_L;

    // Saturating accumulate of the signed term.
    assign term    = r_neg ? (~(SUM_W+1)'(r_mag) + 1'b1) : (SUM_W+1)'(r_mag);
    assign acc_sum = {r_sum[SUM_W-1], r_sum} + term;

    always_comb begin
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
            n_sum = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = acc_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_sum       <= '0;
            r_inf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            // The emit state reloads the output register on its own.
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_p    <= i_prob_a;
                        r_q    <= i_prob_b;
                        r_last <= i_last_bin;
                        r_y    <= norm.mant;
                        r_e    <= norm.expo;
                        r_cnt  <= '0;
                        if (counted && (i_prob_b != '0)) begin
                            r_state <= S_LOGP;
                        end else begin
                            if (counted) begin
                                r_inf <= 1'b1;
                            end
                            if (i_last_bin) begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_LOGP: begin
                    r_frac <= n_frac;
                    if (r_cnt == CNT_LAST) begin
                        r_lp    <= n_lp;
                        r_y     <= norm.mant;
                        r_e     <= norm.expo;
                        r_cnt   <= '0;
                        r_state <= S_LOGQ;
                    end else begin
                        r_y   <= n_y;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_LOGQ: begin
                    r_y    <= n_y;
                    r_frac <= n_frac;
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DIFF;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIFF: begin
                    r_neg   <= diff[LOG_W];
                    r_m     <= diff_abs[M_W-1:0];
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_l     <= mul_p[M_W-1:0];
                    r_state <= S_MUL_F;
                end
                S_MUL_F: begin
                    r_l     <= r_l + M_W'(mul_p >> FRAC_BITS);
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_mag   <= mul_p[T_W +: MAG_W];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= n_sum;
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_div   <= r_inf ? SUM_MAX : r_sum;
                        r_out_inf   <= r_inf;
                        r_sum       <= '0;
                        r_inf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_divergence = $signed(r_out_div);
    assign o_infinite   = r_out_inf;

    // The mantissa stays normalized to [1.0, 2.0) through every squaring step.
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOGP || r_state == S_LOGQ) |-> r_y[MANT_W-1])
        else $error("mantissa left the range [1.0, 2.0)");

    // An infinite result always reports the positive limit.
    a_inf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_infinite) |-> (r_out_div == SUM_MAX))
        else $error("infinite result without saturated divergence");

    // Handing a result to the output register clears the histogram state.
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || !i_stall))
        |=> (r_sum == '0 && !r_inf && o_valid && !o_stall))
        else $error("state not cleared after a result");

    // A bin that needs no arithmetic and is not last leaves the block ready.
    a_skip_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_last_bin && !(counted && (i_prob_b != '0)))
        |=> !o_stall)
        else $error("skipped bin held the input channel");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the histogram KL divergence block
// Sends histogram bin pairs through the valid/stall input channel. A local
// bit-accurate model of the fixed-point logarithm and the saturating sum
// predicts each result, and every result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import kld_pkg::*;

    localparam int FRAC_BITS = 24;

    // A counted bin keeps the block busy through its squaring and multiply
    // steps, plus the load of the output register. Allow some slack on top.
    localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 16;

    // Longest quiet stretch that a correct run can show: a sender gap, a full
    // bin computation, a receiver stall and the settle pause before a
    // threshold write, taken several times over.
    localparam int STALL_LIMIT = 2000;

    localparam int PHASE_BINS = 100;
    localparam int N_PHASES   = 6;

    localparam logic [P_W-1:0] ONE_Q24  = 25'h1000000;
    localparam logic [P_W-1:0] PROB_TOP = 25'h1FFFFFF;
    localparam logic [P_W-1:0] HALF_Q24 = 25'h0800000;

    localparam longint ACC_HI = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) << (SUM_W - 1));

    typedef struct {
        logic signed [SUM_W-1:0] div;
        logic                    inf;
    } t_kl_result;

    // One row of the directed table. When typed is set, the expected result
    // is given in the row; otherwise the model below supplies it.
    typedef struct {
        logic [P_W-1:0]          p;
        logic [P_W-1:0]          q;
        logic                    last;
        logic                    typed;
        logic signed [SUM_W-1:0] div;
        logic                    inf;
    } t_bin_row;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    logic                    i_cfg_we = 1'b0;
    logic [T_W-1:0]          i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [P_W-1:0]          i_prob_a = '0;
    logic [P_W-1:0]          i_prob_b = '0;
    logic                    i_last_bin = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [SUM_W-1:0] o_divergence;
    logic                    o_infinite;

    histogram_kl_divergence_top #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_prob_a     (i_prob_a),
        .i_prob_b     (i_prob_b),
        .i_last_bin   (i_last_bin),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_divergence (o_divergence),
        .o_infinite   (o_infinite)
    );

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Divergence model: threshold, running sum and sticky infinity flag
    // ------------------------------------------------------------------------
    logic [T_W-1:0] skip_level = THR_RESET;
    longint         sum_model = 0;
    logic           inf_model = 1'b0;

    t_kl_result     expected_sums[$];

    int error_count = 0;
    int bins_sent = 0;
    int sums_checked = 0;
    int inf_checked = 0;
    int levels_used = 1;

    // When set, both sides run without idle cycles for a while.
    logic no_idle = 1'b0;

    // log2(x / 2^24) with FRAC_BITS fraction bits, by repeated squaring of
    // the normalized Q1.30 mantissa. x must be nonzero.
    function automatic longint log2_fixed(input logic [P_W-1:0] x);
        int          lead;
        int          i;
        logic [63:0] mant;
        logic [63:0] frac;
        lead = 0;
        while (lead < 24 && (x >> (lead + 1)) != 0)
            lead++;
        mant = 64'(x) << (30 - lead);
        frac = '0;
        for (i = 0; i < FRAC_BITS; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(lead - 24) * (longint'(1) << FRAC_BITS) + longint'(frac);
    endfunction

    // p*ln(p/q) in Q.24, rounded toward zero.
    function automatic longint kl_bin_term(input logic [P_W-1:0] p,
                                           input logic [P_W-1:0] q);
        longint      diff;
        logic        neg;
        logic [63:0] mag_log2;
        logic [63:0] ln2_c;
        logic [63:0] int_part;
        logic [63:0] frac_part;
        logic [63:0] ln_mag;
        logic [63:0] term_mag;
        diff = log2_fixed(p) - log2_fixed(q);
        neg = diff < 0;
        mag_log2 = neg ? 64'(-diff) : 64'(diff);
        ln2_c = 64'(LN2_Q32) >> (32 - FRAC_BITS);
        int_part = mag_log2 >> FRAC_BITS;
        frac_part = mag_log2 & ((64'd1 << FRAC_BITS) - 1);
        ln_mag = int_part * ln2_c + ((frac_part * ln2_c) >> FRAC_BITS);
        if (FRAC_BITS >= 24)
            ln_mag = ln_mag >> (FRAC_BITS - 24);
        else
            ln_mag = ln_mag << (24 - FRAC_BITS);
        term_mag = (64'(p) * ln_mag) >> 24;
        return neg ? -longint'(term_mag) : longint'(term_mag);
    endfunction

    // Folds one bin into the model state. Returns 1 and fills res when the
    // bin closes a histogram.
    function automatic bit fold_bin(input logic [P_W-1:0] p,
                                    input logic [P_W-1:0] q,
                                    input logic last,
                                    output t_kl_result res);
        longint acc;
        res.div = '0;
        res.inf = 1'b0;
        if ((p > skip_level || q > skip_level) && p != '0) begin
            if (q == '0) begin
                inf_model = 1'b1;
            end else begin
                acc = sum_model + kl_bin_term(p, q);
                if (acc > ACC_HI)
                    acc = ACC_HI;
                if (acc < ACC_LO)
                    acc = ACC_LO;
                sum_model = acc;
            end
        end
        if (!last)
            return 1'b0;
        res.div = inf_model ? SUM_MAX : sum_model[SUM_W-1:0];
        res.inf = inf_model;
        sum_model = 0;
        inf_model = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Presents one bin after a random gap and holds it until the beat is
    // taken. Returns at the clock step of acceptance with i_valid still high.
    task automatic send_bin(input logic [P_W-1:0] p, input logic [P_W-1:0] q,
                            input logic last, input logic typed,
                            input logic signed [SUM_W-1:0] typed_div,
                            input logic typed_inf);
        int         gap;
        t_kl_result res;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_prob_a <= p;
        i_prob_b <= q;
        i_last_bin <= last;
        do @(posedge i_clk); while (o_stall);
        bins_sent++;
        if (fold_bin(p, q, last, res)) begin
            if (typed) begin
                res.div = typed_div;
                res.inf = typed_inf;
            end
            expected_sums = {expected_sums, res};
        end
    endtask

    // Drops valid, waits for every expected sum and then for the block to
    // finish any bin still in flight, so the threshold can be changed safely.
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [T_W-1:0] level);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= level;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        skip_level = level;
        levels_used++;
    endtask

    // Bin values aimed at the interesting spots: zero, exactly one, values
    // above one, the skip threshold and its neighbours, and tiny values.
    function automatic logic [P_W-1:0] pick_prob();
        longint near;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_Q24;
            2: return P_W'($urandom_range(0, 32'h1FFFFFF));
            3: return P_W'($urandom_range(0, 32'h1000000));
            4: begin
                near = longint'(skip_level) + 2 - longint'($urandom_range(0, 4));
                if (near < 0)
                    near = 0;
                return P_W'(near);
            end
            5: return P_W'($urandom_range(0, 64));
            6: return $urandom_range(0, 1) ? PROB_TOP : P_W'(1);
            default: return P_W'($urandom_range(32'h100000, 32'h1000000));
        endcase
    endfunction

    // Mostly whole histograms of 1 to 12 bins closed by a last bin; now and
    // then a noisy run where the last flag is drawn per bin. The phase always
    // ends on a last bin so that nothing stays open across a threshold write.
    task automatic run_random_phase(input int n_bins);
        int   left;
        int   hist_len;
        int   k;
        logic noisy;
        logic last;
        left = n_bins;
        while (left > 0) begin
            noisy = ($urandom_range(0, 9) == 0);
            no_idle = ($urandom_range(0, 4) == 0);
            hist_len = $urandom_range(1, 12);
            if (hist_len > left)
                hist_len = left;
            for (k = 0; k < hist_len; k++) begin
                last = noisy ? ($urandom_range(0, 3) == 0) : (k == hist_len - 1);
                if (left == 1)
                    last = 1'b1;
                send_bin(pick_prob(), pick_prob(), last, 1'b0, '0, 1'b0);
                left--;
            end
        end
        no_idle = 1'b0;
    endtask

    // Directed bins, all at the reset threshold. Typed rows are the cases
    // whose sum is obvious: skipped bins, equal values, zero p, zero q.
    t_bin_row directed_bins[] = '{
        '{'0,       '0,       1'b1, 1'b1, '0,      1'b0},  // nothing counted
        '{ONE_Q24,  ONE_Q24,  1'b1, 1'b1, '0,      1'b0},  // equal bins
        '{ONE_Q24,  '0,       1'b1, 1'b1, SUM_MAX, 1'b1},  // q zero
        '{'0,       ONE_Q24,  1'b1, 1'b1, '0,      1'b0},  // p zero, not counted
        '{25'd16,   25'd16,   1'b1, 1'b1, '0,      1'b0},  // at threshold
        '{25'd17,   25'd16,   1'b0, 1'b0, '0,      1'b0},  // just above it
        '{PROB_TOP, 25'd1,    1'b0, 1'b0, '0,      1'b0},  // largest term
        '{25'd1,    PROB_TOP, 1'b1, 1'b0, '0,      1'b0},  // negative term
        '{ONE_Q24,  '0,       1'b0, 1'b0, '0,      1'b0},
        '{ONE_Q24,  HALF_Q24, 1'b1, 1'b1, SUM_MAX, 1'b1},  // flag is sticky
        '{'0,       '0,       1'b1, 1'b1, '0,      1'b0},  // state was cleared
        '{HALF_Q24, ONE_Q24,  1'b0, 1'b0, '0,      1'b0},
        '{ONE_Q24,  HALF_Q24, 1'b0, 1'b0, '0,      1'b0},
        '{25'd16,   '0,       1'b1, 1'b0, '0,      1'b0},  // skipped, q zero
        '{PROB_TOP, PROB_TOP, 1'b1, 1'b1, '0,      1'b0},  // equal, above one
        '{25'h1555555, 25'h0AAAAAA, 1'b1, 1'b0, '0, 1'b0},
        '{25'd5,    '0,       1'b1, 1'b1, '0,      1'b0},  // tiny, skipped
        '{PROB_TOP, '0,       1'b1, 1'b1, SUM_MAX, 1'b1},
        '{25'h0000123, 25'h1F00000, 1'b0, 1'b0, '0, 1'b0},
        '{25'h1F00000, 25'h0000123, 1'b1, 1'b0, '0, 1'b0}
    };

    initial begin : stimulus
        int             i;
        logic [T_W-1:0] levels[N_PHASES];
        levels[0] = '0;
        levels[1] = {T_W{1'b1}};
        levels[2] = T_W'($urandom_range(0, 32'hFFFFFF));
        levels[3] = T_W'($urandom_range(0, 4096));
        levels[4] = THR_RESET;
        levels[5] = T_W'($urandom_range(32'h100000, 32'hFFFFFF));

        @(posedge i_clk iff i_rst_n);

        foreach (directed_bins[row])
            send_bin(directed_bins[row].p, directed_bins[row].q,
                     directed_bins[row].last, directed_bins[row].typed,
                     directed_bins[row].div, directed_bins[row].inf);

        // Each phase starts with the block idle and every sum delivered, so
        // the sender here also pauses for the whole pipeline to empty.
        for (i = 0; i < N_PHASES; i++) begin
            drain_and_settle();
            write_threshold(levels[i]);
            run_random_phase(PHASE_BINS);
        end

        i_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_sums.size() != 0) begin
            $error("%0d expected sums never arrived", expected_sums.size());
            error_count++;
        end
        $display("Covered %0d bins and %0d histogram sums (%0d infinite) over %0d",
                 bins_sent, sums_checked, inf_checked, levels_used);
        $display("skip thresholds, from zero up to the full 24-bit value.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Per result, the receiver either takes the beat at once or holds stall
    // for a random number of cycles after the result shows up.
    initial begin : receiver
        int hold;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
                repeat (hold - 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Every result beat is matched against the oldest expected sum.
    always @(posedge i_clk) begin
        t_kl_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sums.size() == 0) begin
                $error("result beat with no sum expected: divergence %0d infinite %0b",
                       o_divergence, o_infinite);
                error_count++;
            end else begin
                want = expected_sums.pop_front();
                sums_checked++;
                if (want.inf)
                    inf_checked++;
                if (o_divergence !== want.div) begin
                    $error("divergence mismatch: expected %0d, actual %0d",
                           want.div, o_divergence);
                    error_count++;
                end
                if (o_infinite !== want.inf) begin
                    $error("infinite mismatch: expected %0b, actual %0b",
                           want.inf, o_infinite);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too
    // long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

>>> histogram_kl_divergence_top.f
rtl/kld_pkg.sv
rtl/kld_norm.sv
rtl/kld_mul.sv
rtl/histogram_kl_divergence_top.sv
dv/tb_top.sv
